/* sv/fan_curve_duty_controller_defines.svh */
// Assertion macros shared by the fan curve duty controller.
`ifndef FAN_CURVE_DUTY_CONTROLLER_DEFINES_SVH
`define FAN_CURVE_DUTY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define FCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fan curve duty controller: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define FCD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fan curve duty controller: next-cycle check failed");

`endif

/* sv/fcd_pkg.sv */
// Package with the shared types and constants of the fan curve duty controller.
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int CoolDepth = 5;
  localparam int MaxPoints = 8;

  localparam logic [7:0] FullDutyRst = 8'd255;

  typedef enum logic [2:0] {
    CfgCurveTemps  = 3'd0,
    CfgCurveDuties = 3'd1,
    CfgPointsUsed  = 3'd2,
    CfgMinDuty     = 3'd3,
    CfgFullDuty    = 3'd4,
    CfgUseGpuTemp  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic fire;
    logic duty_tick;
    logic force_max;
    logic in_s0;
  } tick_t;

endpackage

/* sv/fcd_curve.sv */
// Stepwise fan curve lookup over all points in parallel.
`timescale 1ns / 1ps

module fcd_curve (
  input  logic signed [7:0]  peak_temp_i,
  input  logic        [63:0] curve_temps_i,
  input  logic        [63:0] curve_duties_i,
  input  logic        [3:0]  points_used_i,
  input  logic        [7:0]  full_duty_i,
  output logic        [7:0]  curve_duty_o
);

  logic        [3:0]  n_pts;
  logic        [63:0] prev_duties;
  logic signed [7:0]  pt_temp;

  assign n_pts = (points_used_i > 4'(fcd_pkg::MaxPoints)) ? 4'(fcd_pkg::MaxPoints)
                                                          : points_used_i;
  assign prev_duties = {curve_duties_i[55:0], 8'h00};

  // The lowest point at or above the temperature decides, so scan downwards.
  always_comb begin
    curve_duty_o = full_duty_i;
    pt_temp      = '0;
    for (int k = fcd_pkg::MaxPoints - 1; k >= 0; k--) begin
      pt_temp = signed'(curve_temps_i[k*8 +: 8]);
      if ((4'(k) < n_pts) && (peak_temp_i <= pt_temp)) begin
        if (peak_temp_i == pt_temp) begin
          curve_duty_o = curve_duties_i[k*8 +: 8];
        end else begin
          curve_duty_o = prev_duties[k*8 +: 8];
        end
      end
    end
  end

endmodule

/* sv/fcd_core.sv */
// Target and driven duty state with the cooldown history and the duty ramp.
`timescale 1ns / 1ps

module fcd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcd_pkg::tick_t    tick_i,
  input  logic        [7:0] curve_duty_i,
  input  logic        [7:0] min_duty_i,
  input  logic        [7:0] full_duty_i,
  output logic        [7:0] target_duty_o,
  output logic        [7:0] actual_duty_o
);

  logic [7:0] hist_q [fcd_pkg::CoolDepth];
  logic [7:0] hist_d [fcd_pkg::CoolDepth];
  logic [7:0] target_q, target_d;
  logic [7:0] actual_q, actual_d;
  logic [7:0] window_max;
  logic [7:0] step_up, step_dn;
  logic       hist_upd;

  assign hist_upd = tick_i.fire && !tick_i.duty_tick && !tick_i.force_max && tick_i.in_s0;

  always_comb begin
    window_max = curve_duty_i;
    for (int k = 1; k < fcd_pkg::CoolDepth; k++) begin
      if (hist_q[k] > window_max) begin
        window_max = hist_q[k];
      end
    end
    for (int k = 0; k < fcd_pkg::CoolDepth - 1; k++) begin
      hist_d[k] = hist_q[k+1];
    end
    hist_d[fcd_pkg::CoolDepth-1] = curve_duty_i;
  end

  assign step_up = actual_q + 8'd1;
  assign step_dn = actual_q - 8'd1;

  always_comb begin
    target_d = target_q;
    actual_d = actual_q;
    if (tick_i.fire) begin
      if (!tick_i.duty_tick) begin
        if (tick_i.force_max) begin
          target_d = full_duty_i;
        end else if (!tick_i.in_s0) begin
          target_d = '0;
        end else begin
          target_d = window_max;
        end
      end else begin
        if (tick_i.force_max) begin
          actual_d = full_duty_i;
        end else if (!tick_i.in_s0) begin
          actual_d = '0;
        end else if (actual_q < target_q) begin
          if (actual_q < full_duty_i) begin
            actual_d = (step_up < min_duty_i) ? min_duty_i : step_up;
          end
        end else if (actual_q > target_q) begin
          actual_d = (step_dn < min_duty_i) ? 8'd0 : step_dn;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      actual_q <= '0;
      for (int k = 0; k < fcd_pkg::CoolDepth; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      target_q <= target_d;
      actual_q <= actual_d;
      if (hist_upd) begin
        hist_q <= hist_d;
      end
    end
  end

  assign target_duty_o = target_q;
  assign actual_duty_o = actual_q;

endmodule

/* sv/fan_curve_duty_controller.sv */
// Top level of the fan curve duty controller: ports, registers and pipeline control.
//
// Each accepted beat is one tick and gives exactly one result beat carrying the target
// and driven duty after that tick. A beat waits in the input register, where
// the curve lookup, the cooldown window maximum and the ramp step are worked out in one
// pass, and the state updates as the result register loads; the result is registered, and
// a new beat can be taken every cycle while the result is not stalled. A stalled result
// holds the input register, and then in_stall_o rises. Configuration writes are always
// ready and take effect at once; write them only while no tick is in flight.
`timescale 1ns / 1ps

`include "fan_curve_duty_controller_defines.svh"

module fan_curve_duty_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [7:0]  cpu_temp_i,
  input  logic signed [7:0]  gpu_temp_i,
  input  logic               force_max_i,
  input  logic               in_s0_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [7:0]  target_duty_o,
  output logic        [7:0]  actual_duty_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [63:0] cfg_data_i
);

  logic [63:0] curve_temps_q;
  logic [63:0] curve_duties_q;
  logic [3:0]  points_used_q;
  logic [7:0]  min_duty_q;
  logic [7:0]  full_duty_q;
  logic        use_gpu_temp_q;

  logic              stage_valid_q;
  logic              req_type_q;
  logic signed [7:0] cpu_temp_q;
  logic signed [7:0] gpu_temp_q;
  logic              force_max_q;
  logic              in_s0_q;
  logic              out_valid_q;

  logic              fire;
  logic              in_accept;
  logic signed [7:0] peak_temp;
  logic        [7:0] curve_duty;
  fcd_pkg::tick_t    tick;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_temps_q  <= '0;
      curve_duties_q <= '0;
      points_used_q  <= '0;
      min_duty_q     <= '0;
      full_duty_q    <= fcd_pkg::FullDutyRst;
      use_gpu_temp_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fcd_pkg::cfg_idx_e'(cfg_index_i))
        fcd_pkg::CfgCurveTemps:  curve_temps_q  <= cfg_data_i;
        fcd_pkg::CfgCurveDuties: curve_duties_q <= cfg_data_i;
        fcd_pkg::CfgPointsUsed:  points_used_q  <= cfg_data_i[3:0];
        fcd_pkg::CfgMinDuty:     min_duty_q     <= cfg_data_i[7:0];
        fcd_pkg::CfgFullDuty:    full_duty_q    <= cfg_data_i[7:0];
        fcd_pkg::CfgUseGpuTemp:  use_gpu_temp_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign fire       = stage_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stage_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        stage_valid_q <= 1'b1;
      end else if (fire) begin
        stage_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_type_q  <= req_type_i;
      cpu_temp_q  <= cpu_temp_i;
      gpu_temp_q  <= gpu_temp_i;
      force_max_q <= force_max_i;
      in_s0_q     <= in_s0_i;
    end
  end

  assign peak_temp = (use_gpu_temp_q && (gpu_temp_q > cpu_temp_q)) ? gpu_temp_q : cpu_temp_q;

  fcd_curve u_curve (
    .peak_temp_i    (peak_temp),
    .curve_temps_i  (curve_temps_q),
    .curve_duties_i (curve_duties_q),
    .points_used_i  (points_used_q),
    .full_duty_i    (full_duty_q),
    .curve_duty_o   (curve_duty)
  );

  assign tick.fire      = fire;
  assign tick.duty_tick = req_type_q;
  assign tick.force_max = force_max_q;
  assign tick.in_s0     = in_s0_q;

  fcd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .curve_duty_i  (curve_duty),
    .min_duty_i    (min_duty_q),
    .full_duty_i   (full_duty_q),
    .target_duty_o (target_duty_o),
    .actual_duty_o (actual_duty_o)
  );

  assign out_valid_o = out_valid_q;

  `FCD_ASSERT_NXT(a_force_duty_full, fire && req_type_q && force_max_q, actual_duty_o == $past(full_duty_q))
  `FCD_ASSERT_NXT(a_target_tick_keeps_actual, fire && !req_type_q, $stable(actual_duty_o))
  `FCD_ASSERT_NXT(a_duty_tick_keeps_target, fire && req_type_q, $stable(target_duty_o))
  `FCD_ASSERT_NXT(a_target_covers_curve, fire && !req_type_q && !force_max_q && in_s0_q, target_duty_o >= $past(curve_duty))

endmodule
